// ===== rtl/hbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types, codes and defaults for the Huffman bitstream decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

  // Default sizes
  localparam int NODE_COUNT_DEF    = 256;
  localparam int SYMBOL_COUNT_DEF  = 128;
  localparam int MAX_CODE_BITS_DEF = 127;

  // Fixed field widths
  localparam int SYM_W    = 7;
  localparam int LEN_W    = 7;
  localparam int CODE_W   = 127;
  localparam int BYTE_W   = 8;
  localparam int BV_W     = 4;
  localparam int ST_W     = 2;
  localparam int SYM_SPAN = 128;   // every value the symbol field can carry

  // Action codes
  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DECODE = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_SYMBOL = 2'd0;
  localparam logic [ST_W-1:0] ST_BROKEN = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_length;
    logic [63:0]       code_low;
    logic [62:0]       code_high;
    logic [BYTE_W-1:0] payload_byte;
    logic [BV_W-1:0]   bits_valid;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic [ST_W-1:0]  status;
    logic             last;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_INS,
    S_DEC_START,
    S_DEC
  } state_t;

  // Where the current node's entry comes from
  typedef enum logic [1:0] {
    SRC_ROOT,
    SRC_MEM,
    SRC_ZERO
  } src_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted beat
    logic clear;      // cut the tree back to a lone root
    logic dec_sel;    // walk payload bits instead of code bits
    logic ins_step;   // follow an existing child
    logic ins_alloc;  // allocate a missing child and link it
    logic ins_fin;    // store the symbol at the current node
    logic ins_full;   // table full: close the insert with a result
    logic dec_start;  // fetch the saved walk position
    logic dec_leaf;   // emit the leaf just reached
    logic dec_bit;    // walk one payload bit
    logic flush;      // release the held result as last
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic child_zero;
    logic leaf_hit;
    logic full;
    logic bits_left;
    logic hold_v;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/hbd_dpath.sv =====
// ----------------------------------------------------------------------------
// hbd_dpath
// Node table, walk registers, held result and output register.
// ----------------------------------------------------------------------------
module hbd_dpath #(
  parameter int NODE_COUNT    = hbd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_COUNT  = hbd_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = hbd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hbd_pkg::in_item_t  in_data,
  input  hbd_pkg::dp_cmd_t   cmd,
  output hbd_pkg::dp_stat_t  stat,
  output logic               out_valid,
  input  logic               out_ready,
  output hbd_pkg::out_item_t out_data
);
  import hbd_pkg::*;

  localparam int NW = $clog2(NODE_COUNT);
  localparam int UW = $clog2(NODE_COUNT + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CODE_BITS);
  localparam logic [UW-1:0] USED_MAX = UW'(NODE_COUNT);

  typedef struct packed {
    logic [NW-1:0]    left;
    logic [NW-1:0]    right;
    logic [SYM_W-1:0] sym;
  } ent_t;

  // Node table
  ent_t node_mem [NODE_COUNT];
  ent_t rd_r;
  ent_t root_r;

  // Walk and item registers
  logic [NW-1:0]     cur_r;
  logic [NW-1:0]     walk_r;
  src_t              src_r;
  logic              chk_r;
  logic [UW-1:0]     used_r;
  logic [LEN_W-1:0]  cnt_r;
  logic [CODE_W-1:0] code_r;
  logic [BYTE_W-1:0] byte_r;
  logic [SYM_W-1:0]  sym_r;

  // Held result and output register
  logic              hold_v_r;
  logic [SYM_W-1:0]  hold_sym_r;
  logic [ST_W-1:0]   hold_st_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  // Symbol reduction table
  logic [SYM_W-1:0] mod_tbl [SYM_SPAN];
  for (genvar k = 0; k < SYM_SPAN; k++) begin : g_mod
    assign mod_tbl[k] = SYM_W'(k % SYMBOL_COUNT);
  end

  // Current entry, selected bit and its child
  logic              leaf_hit;
  ent_t              ent;
  logic              bit_v;
  logic [NW-1:0]     child;
  logic              child_zero;
  logic              full;
  logic              out_free;
  logic [NW-1:0]     new_idx;
  logic [LEN_W-1:0]  len_clamp;
  logic [LEN_W-1:0]  bv_clamp;

  assign leaf_hit = chk_r && (rd_r.left == '0) && (rd_r.right == '0);

  always_comb begin
    case (src_r)
      SRC_MEM:  ent = leaf_hit ? root_r : rd_r;
      SRC_ZERO: ent = '0;
      default:  ent = root_r;
    endcase
  end

  assign bit_v      = cmd.dec_sel ? byte_r[BYTE_W-1] : code_r[cnt_r - LEN_W'(1)];
  assign child      = bit_v ? ent.right : ent.left;
  assign child_zero = (child == '0);
  assign full       = (used_r == USED_MAX);
  assign out_free   = !out_valid_r || out_ready;
  assign new_idx    = used_r[NW-1:0];
  assign len_clamp  = (in_data.code_length > LEN_MAX) ? LEN_MAX : in_data.code_length;
  assign bv_clamp   = (in_data.bits_valid > BV_W'(BYTE_W)) ? LEN_W'(BYTE_W)
                                                           : LEN_W'(in_data.bits_valid);

  assign stat.child_zero = child_zero;
  assign stat.leaf_hit   = leaf_hit;
  assign stat.full       = full;
  assign stat.bits_left  = (cnt_r != '0);
  assign stat.hold_v     = hold_v_r;
  assign stat.out_free   = out_free;

  // Table write and read port selection
  logic          we;
  logic [NW-1:0] waddr;
  ent_t          wdata;
  logic          re;
  logic [NW-1:0] raddr;

  always_comb begin
    we    = 1'b0;
    waddr = cur_r;
    wdata = ent;
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '0;
    end else if (cmd.ins_alloc) begin
      we = 1'b1;
      if (bit_v) begin
        wdata.right = new_idx;
      end else begin
        wdata.left = new_idx;
      end
    end else if (cmd.ins_fin) begin
      we        = 1'b1;
      wdata.sym = sym_r;
    end else if (cmd.ins_full) begin
      we = 1'b1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = child;
    if (cmd.dec_start) begin
      re    = (walk_r != '0);
      raddr = walk_r;
    end else if (cmd.ins_step || (cmd.dec_bit && !child_zero)) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      node_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= node_mem[raddr];
    end
  end

  // Keep a copy of the root so a walk restarts without a read
  always_ff @(posedge clk) begin
    if (we && (waddr == '0)) begin
      root_r <= wdata;
    end
  end

  // Item capture and walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= UW'(1);
      walk_r <= '0;
      chk_r  <= 1'b0;
      src_r  <= SRC_ROOT;
    end else begin
      if (cmd.load) begin
        cnt_r  <= (in_data.action == ACT_DECODE) ? bv_clamp : len_clamp;
        code_r <= {in_data.code_high, in_data.code_low};
        byte_r <= in_data.payload_byte;
        sym_r  <= mod_tbl[in_data.symbol];
        cur_r  <= '0;
        src_r  <= SRC_ROOT;
        chk_r  <= 1'b0;
      end
      if (cmd.clear) begin
        used_r <= UW'(1);
        walk_r <= '0;
      end
      if (cmd.ins_step) begin
        cur_r <= child;
        src_r <= SRC_MEM;
        cnt_r <= cnt_r - LEN_W'(1);
      end
      if (cmd.ins_alloc) begin
        cur_r  <= new_idx;
        src_r  <= SRC_ZERO;
        cnt_r  <= cnt_r - LEN_W'(1);
        used_r <= used_r + UW'(1);
      end
      if (cmd.dec_start) begin
        src_r <= (walk_r == '0) ? SRC_ROOT : SRC_MEM;
        chk_r <= 1'b0;
      end
      // Walk one payload bit; a leaf emitted with no bit walked returns to root
      if (cmd.dec_bit) begin
        cnt_r  <= cnt_r - LEN_W'(1);
        byte_r <= {byte_r[BYTE_W-2:0], 1'b0};
        if (child_zero) begin
          walk_r <= '0;
          src_r  <= SRC_ROOT;
          chk_r  <= 1'b0;
        end else begin
          walk_r <= child;
          src_r  <= SRC_MEM;
          chk_r  <= 1'b1;
        end
      end else if (cmd.dec_leaf) begin
        walk_r <= '0;
        src_r  <= SRC_ROOT;
        chk_r  <= 1'b0;
      end
    end
  end

  // Result production: one result is held back until its last flag is known
  logic             produce;
  logic [SYM_W-1:0] new_sym;
  logic [ST_W-1:0]  new_st;
  logic             push;
  out_item_t        push_data;

  assign produce = cmd.dec_leaf || (cmd.dec_bit && child_zero);
  assign new_sym = cmd.dec_leaf ? rd_r.sym : '0;
  assign new_st  = cmd.dec_leaf ? ST_SYMBOL : ST_BROKEN;
  assign push    = (produce && hold_v_r) || cmd.flush || cmd.ins_full;

  always_comb begin
    push_data.symbol_out = hold_sym_r;
    push_data.status     = hold_st_r;
    push_data.last       = cmd.flush;
    if (cmd.ins_full) begin
      push_data.symbol_out = '0;
      push_data.status     = ST_FULL;
      push_data.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (produce) begin
      hold_v_r <= 1'b1;
    end else if (cmd.flush) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      hold_sym_r <= new_sym;
      hold_st_r  <= new_st;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed over an unaccepted result");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != '0) && (used_r <= USED_MAX))
    else $error("node count out of range");

  a_chk_mem: assert property (@(posedge clk) disable iff (!rst_n)
    chk_r |-> (src_r == SRC_MEM))
    else $error("leaf check pending without table data");

endmodule

// ===== rtl/hbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbd_ctrl
// Sequencer for clear, insert and decode items.
// ----------------------------------------------------------------------------
module hbd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_action,
  input  hbd_pkg::dp_stat_t stat,
  output hbd_pkg::dp_cmd_t  cmd
);
  import hbd_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   can_prod;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign can_prod = !stat.hold_v || stat.out_free;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_action)
            ACT_CLEAR:  cmd.clear = 1'b1;
            ACT_INSERT: state_nxt = S_INS;
            ACT_DECODE: state_nxt = S_DEC_START;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (!stat.bits_left) begin
          cmd.ins_fin = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!stat.child_zero) begin
          cmd.ins_step = 1'b1;
        end else if (!stat.full) begin
          cmd.ins_alloc = 1'b1;
        end else if (stat.out_free) begin
          cmd.ins_full = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DEC_START: begin
        cmd.dec_sel   = 1'b1;
        cmd.dec_start = 1'b1;
        state_nxt     = S_DEC;
      end
      S_DEC: begin
        cmd.dec_sel = 1'b1;
        if (stat.leaf_hit) begin
          // Emit the leaf; walk on only if the next bit adds no result
          if (can_prod) begin
            cmd.dec_leaf = 1'b1;
            cmd.dec_bit  = stat.bits_left && !stat.child_zero;
          end
        end else if (stat.bits_left) begin
          cmd.dec_bit = !stat.child_zero || can_prod;
        end else if (stat.hold_v) begin
          if (stat.out_free) begin
            cmd.flush = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  // Checks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !stat.hold_v)
    else $error("held result left behind at end of item");

  a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |-> stat.out_free)
    else $error("flush while output register is busy");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.dec_leaf && cmd.dec_bit) |-> !stat.child_zero)
    else $error("two results in one cycle");

endmodule

// ===== rtl/huffman_bitstream_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_bitstream_decoder
// Decode: one tree step per payload bit; a leaf that ends the byte or is
// directly followed by a missing child takes its own step, and out_ready
// stalls hold the walk. Insert: one dependent table access per code bit.
// Clear and unused actions return straight to idle. After reset a root write runs
// before the first item is accepted; the tree is then a lone root.
// ----------------------------------------------------------------------------
module huffman_bitstream_decoder #(
  parameter int NODE_COUNT    = hbd_pkg::NODE_COUNT_DEF,
  parameter int SYMBOL_COUNT  = hbd_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_BITS = hbd_pkg::MAX_CODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hbd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hbd_pkg::out_item_t out_data
);
  import hbd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  hbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_data.action),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Node table and result path
  hbd_dpath #(
    .NODE_COUNT    (NODE_COUNT),
    .SYMBOL_COUNT  (SYMBOL_COUNT),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
